// File: rtl/lqb_pkg.sv
// ----------------------------------------------------------------------------
// Linear quadtree box index package
// Shared widths, register indexes, the queue entry type and level offsets.
// ----------------------------------------------------------------------------
package lqb_pkg;

    localparam int COORD_BITS = 24;
    localparam int MAX_LEVEL  = 8;
    localparam int LEVEL_BITS = 4;
    localparam int CODE_BITS  = 2 * MAX_LEVEL;
    localparam int INDEX_BITS = 17;
    localparam int QUO_BITS   = MAX_LEVEL + 1;
    localparam int CFG_IDX_BITS = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_WORLD_MIN_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WORLD_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WORLD_MAX_X = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WORLD_MAX_Y = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEVELS      = 3'd4;

    // Corner order inside a request.
    localparam int C_BX = 0;
    localparam int C_BY = 1;
    localparam int C_EX = 2;
    localparam int C_EY = 3;

    // One classified request as it waits for the back end.
    typedef struct packed {
        logic                            hit;
        logic [LEVEL_BITS-1:0]           lv;
        logic [COORD_BITS-1:0]           width_x;
        logic [COORD_BITS-1:0]           width_y;
        logic [3:0][COORD_BITS-1:0]      off;
    } lqb_entry_t;

    // Start of each level in the linear index: (4^level - 1) / 3.
    function automatic logic [INDEX_BITS-1:0] level_offset(input logic [LEVEL_BITS-1:0] lev);
        logic [INDEX_BITS-1:0] r;
        begin
            r = '0;
            case (lev)
                4'd0:    r = 17'd0;
                4'd1:    r = 17'd1;
                4'd2:    r = 17'd5;
                4'd3:    r = 17'd21;
                4'd4:    r = 17'd85;
                4'd5:    r = 17'd341;
                4'd6:    r = 17'd1365;
                4'd7:    r = 17'd5461;
                4'd8:    r = 17'd21845;
                default: r = 17'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: rtl/lqb_front.sv
// ----------------------------------------------------------------------------
// Linear quadtree box index front end
// Holds the configuration, tests the box against the world and clamps corners.
// ----------------------------------------------------------------------------
module lqb_front
    import lqb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [COORD_BITS-1:0]    box_min_x,
    input  logic [COORD_BITS-1:0]    box_min_y,
    input  logic [COORD_BITS-1:0]    box_max_x,
    input  logic [COORD_BITS-1:0]    box_max_y,
    output logic                     push,
    output lqb_entry_t               push_entry,
    input  logic                     queue_full
);

    logic signed [COORD_BITS-1:0] wmin_x_reg, wmin_y_reg, wmax_x_reg, wmax_y_reg;
    logic [LEVEL_BITS-1:0]        levels_reg;
    logic                         valid_reg;
    lqb_entry_t                   entry_reg, entry_next;

    logic signed [COORD_BITS:0]   bx0, by0, bx1, by1;
    logic signed [COORD_BITS:0]   mnx, mny, mxx, mxy, lastx, lasty;
    logic signed [COORD_BITS:0]   px0, py0, px1, py1;
    logic signed [COORD_BITS:0]   dx0, dy0, dx1, dy1, wdx, wdy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wmin_x_reg <= '0;
            wmin_y_reg <= '0;
            wmax_x_reg <= 24'sd1024;
            wmax_y_reg <= 24'sd1024;
            levels_reg <= 4'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WORLD_MIN_X: wmin_x_reg <= cfg_data;
                REG_WORLD_MIN_Y: wmin_y_reg <= cfg_data;
                REG_WORLD_MAX_X: wmax_x_reg <= cfg_data;
                REG_WORLD_MAX_Y: wmax_y_reg <= cfg_data;
                REG_LEVELS:      levels_reg <= cfg_data[LEVEL_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Sign-extend everything one bit so that the far edge minus one cannot wrap.
    always_comb
    begin
        bx0   = {box_min_x[COORD_BITS-1], box_min_x};
        by0   = {box_min_y[COORD_BITS-1], box_min_y};
        bx1   = {box_max_x[COORD_BITS-1], box_max_x};
        by1   = {box_max_y[COORD_BITS-1], box_max_y};
        mnx   = {wmin_x_reg[COORD_BITS-1], wmin_x_reg};
        mny   = {wmin_y_reg[COORD_BITS-1], wmin_y_reg};
        mxx   = {wmax_x_reg[COORD_BITS-1], wmax_x_reg};
        mxy   = {wmax_y_reg[COORD_BITS-1], wmax_y_reg};
        lastx = mxx - 25'sd1;
        lasty = mxy - 25'sd1;

        // Clamp the near corner up and the far corner down.
        px0 = (bx0 > mnx) ? bx0 : mnx;
        py0 = (by0 > mny) ? by0 : mny;
        px1 = (bx1 < lastx) ? bx1 : lastx;
        py1 = (by1 < lasty) ? by1 : lasty;

        dx0 = px0 - mnx;
        dy0 = py0 - mny;
        dx1 = px1 - mnx;
        dy1 = py1 - mny;
        wdx = mxx - mnx;
        wdy = mxy - mny;

        entry_next.hit = (mxx > mnx) && (mxy > mny) && (mnx <= bx1) && (bx0 <= mxx)
                         && (mny <= by1) && (by0 <= mxy);
        entry_next.lv  = (levels_reg > LEVEL_BITS'(MAX_LEVEL))
                         ? LEVEL_BITS'(MAX_LEVEL) : levels_reg;
        entry_next.width_x  = wdx[COORD_BITS-1:0];
        entry_next.width_y  = wdy[COORD_BITS-1:0];
        entry_next.off[C_BX] = dx0[COORD_BITS-1:0];
        entry_next.off[C_BY] = dy0[COORD_BITS-1:0];
        entry_next.off[C_EX] = dx1[COORD_BITS-1:0];
        entry_next.off[C_EY] = dy1[COORD_BITS-1:0];
    end

    assign push       = valid_reg && !queue_full;
    assign in_ready   = !valid_reg || !queue_full;
    assign push_entry = entry_reg;

    // Holding register for the classified request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// File: rtl/lqb_fifo.sv
// ----------------------------------------------------------------------------
// Linear quadtree box index request queue
// Two-entry queue that decouples the front end from the divider pipeline.
// ----------------------------------------------------------------------------
module lqb_fifo
    import lqb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  lqb_entry_t  push_entry,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output lqb_entry_t  pop_entry
);

    lqb_entry_t  mem [0:1];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_entry = mem[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/lqb_back.sv
// ----------------------------------------------------------------------------
// Linear quadtree box index back end
// Pipelined restoring division of the four corners, then Morton code and index.
// ----------------------------------------------------------------------------
module lqb_back
    import lqb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    not_empty,
    input  lqb_entry_t              pop_entry,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    hit,
    output logic [INDEX_BITS-1:0]   cell_index,
    output logic [LEVEL_BITS-1:0]   cell_level,
    output logic [CODE_BITS-1:0]    cell_code
);

    localparam int NS = QUO_BITS;

    logic                              advance;
    logic [NS-1:0]                     valid_reg;
    logic                              hit_s_reg   [0:NS-1];
    logic [LEVEL_BITS-1:0]             lv_s_reg    [0:NS-1];
    logic [COORD_BITS-1:0]             wx_s_reg    [0:NS-1];
    logic [COORD_BITS-1:0]             wy_s_reg    [0:NS-1];
    logic [3:0][COORD_BITS-1:0]        rem_s_reg   [0:NS-1];
    logic [3:0][QUO_BITS-1:0]          quo_s_reg   [0:NS-1];
    logic [3:0][COORD_BITS-1:0]        rem_next    [0:NS-1];
    logic [3:0][QUO_BITS-1:0]          quo_next    [0:NS-1];

    logic                              out_valid_reg, hit_reg;
    logic [INDEX_BITS-1:0]             index_reg, index_next;
    logic [LEVEL_BITS-1:0]             level_reg, level_next;
    logic [CODE_BITS-1:0]              code_reg, code_next;

    // The whole pipeline moves when the output register can take a result.
    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && not_empty;

    // One quotient bit per stage and corner. The first stage tests off >= width.
    always_comb
    begin
        logic [COORD_BITS:0] t;
        logic [COORD_BITS:0] w;
        for (int s = 0; s < NS; s++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (s == 0)
                begin
                    t = {1'b0, pop_entry.off[c]};
                    w = {1'b0, (c == C_BX || c == C_EX) ? pop_entry.width_x
                                                        : pop_entry.width_y};
                    quo_next[s][c] = '0;
                end
                else
                begin
                    t = {rem_s_reg[s-1][c], 1'b0};
                    w = {1'b0, (c == C_BX || c == C_EX) ? wx_s_reg[s-1] : wy_s_reg[s-1]};
                    quo_next[s][c] = {quo_s_reg[s-1][c][QUO_BITS-2:0], 1'b0};
                end
                if (t >= w)
                begin
                    t = t - w;
                    quo_next[s][c][0] = 1'b1;
                end
                rem_next[s][c] = t[COORD_BITS-1:0];
            end
        end
    end

    // Division stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[NS-2:0], not_empty};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s < NS; s++)
            begin
                rem_s_reg[s] <= rem_next[s];
                quo_s_reg[s] <= quo_next[s];
                if (s == 0)
                begin
                    hit_s_reg[s] <= pop_entry.hit;
                    lv_s_reg[s]  <= pop_entry.lv;
                    wx_s_reg[s]  <= pop_entry.width_x;
                    wy_s_reg[s]  <= pop_entry.width_y;
                end
                else
                begin
                    hit_s_reg[s] <= hit_s_reg[s-1];
                    lv_s_reg[s]  <= lv_s_reg[s-1];
                    wx_s_reg[s]  <= wx_s_reg[s-1];
                    wy_s_reg[s]  <= wy_s_reg[s-1];
                end
            end
        end
    end

    // Scale to the level, saturate, interleave and find the common cell.
    always_comb
    begin
        logic [LEVEL_BITS-1:0] lv, used;
        logic [3:0][QUO_BITS-1:0] q;
        logic [QUO_BITS-1:0] top;
        logic [CODE_BITS-1:0] cb, ce, diff;
        lv   = lv_s_reg[NS-1];
        top  = QUO_BITS'((1 << lv) - 1);
        for (int c = 0; c < 4; c++)
        begin
            q[c] = quo_s_reg[NS-1][c] >> (LEVEL_BITS'(MAX_LEVEL) - lv);
            if (q[c] > top)
            begin
                q[c] = top;
            end
        end
        cb = '0;
        ce = '0;
        for (int i = 0; i < MAX_LEVEL; i++)
        begin
            cb[2*i]   = q[C_BX][i];
            cb[2*i+1] = q[C_BY][i];
            ce[2*i]   = q[C_EX][i];
            ce[2*i+1] = q[C_EY][i];
        end
        diff = cb ^ ce;
        used = '0;
        for (int i = 0; i < MAX_LEVEL; i++)
        begin
            if (diff[2*i +: 2] != 2'b00)
            begin
                used = LEVEL_BITS'(i + 1);
            end
        end
        level_next = lv - used;
        code_next  = cb >> {used, 1'b0};
        index_next = level_offset(level_next) + INDEX_BITS'(code_next);
        if (!hit_s_reg[NS-1])
        begin
            level_next = '0;
            code_next  = '0;
            index_next = '0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= valid_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_reg   <= hit_s_reg[NS-1];
            index_reg <= index_next;
            level_reg <= level_next;
            code_reg  <= code_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign cell_index = index_reg;
    assign cell_level = level_reg;
    assign cell_code  = code_reg;

endmodule

// File: rtl/linear_quadtree_box_cell_index.sv
// ----------------------------------------------------------------------------
// Linear quadtree box cell index
// Maps an axis-aligned box to the linear quadtree cell that contains it.
// ----------------------------------------------------------------------------
// Takes one box request per cycle while in_ready is high and returns one
// result per request, in order. The front-end register loads at acceptance,
// then the request passes through the request queue, the nine divider
// pipeline stages (one quotient bit per stage for all four corners) and the
// output register. Boxes that miss the world, or a world with an empty
// extent, give hit low with all other fields zero. Configuration must be
// written only while no request is in flight; the block does not enforce it.
module linear_quadtree_box_cell_index
    import lqb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [COORD_BITS-1:0]    box_min_x,
    input  logic [COORD_BITS-1:0]    box_min_y,
    input  logic [COORD_BITS-1:0]    box_max_x,
    input  logic [COORD_BITS-1:0]    box_max_y,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     hit,
    output logic [INDEX_BITS-1:0]    cell_index,
    output logic [LEVEL_BITS-1:0]    cell_level,
    output logic [CODE_BITS-1:0]     cell_code
);

    logic        push, pop, queue_full, not_empty;
    lqb_entry_t  push_entry, pop_entry;

    lqb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .box_min_x  (box_min_x),
        .box_min_y  (box_min_y),
        .box_max_x  (box_max_x),
        .box_max_y  (box_max_y),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (queue_full)
    );

    lqb_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (not_empty),
        .pop_entry  (pop_entry)
    );

    lqb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .not_empty  (not_empty),
        .pop_entry  (pop_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .cell_index (cell_index),
        .cell_level (cell_level),
        .cell_code  (cell_code)
    );

endmodule

// File: rtl/lqb_checker.sv
// ----------------------------------------------------------------------------
// Linear quadtree box index checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module lqb_checker
    import lqb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic                   hit,
    input  logic [INDEX_BITS-1:0]  cell_index,
    input  logic [LEVEL_BITS-1:0]  cell_level,
    input  logic [CODE_BITS-1:0]   cell_code
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_index) && $stable(hit))
        else $error("stalled result changed");

    // A miss carries no cell.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> cell_index == '0 && cell_level == '0 && cell_code == '0)
        else $error("miss with nonzero cell fields");

    // The level never exceeds the deepest level.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> cell_level <= LEVEL_BITS'(MAX_LEVEL))
        else $error("cell level out of range");

    // The root cell is index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit && cell_level == '0 |-> cell_index == '0 && cell_code == '0)
        else $error("root cell with nonzero index");

endmodule

bind linear_quadtree_box_cell_index lqb_checker u_lqb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .cell_index (cell_index),
    .cell_level (cell_level),
    .cell_code  (cell_code)
);
